>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: shared assertion macros for the rasterizer rtl
// clocked property checks with an active low reset that disables them
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

>>> sv/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg: shared types and constants of the line segment rasterizer
// item kinds, configuration register indexes, default coordinate width
// ----------------------------------------------------------------------------
`default_nettype none

package lsr_pkg;

	// default coordinate width in bits
	localparam int unsigned LSR_COORD_BITS = 12;

	// configuration register index width
	localparam int unsigned CFG_IDX_BITS = 2;

	// input item kinds
	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_STEP = 1'b1
	} item_kind_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_GRID_WIDTH = 2'd0,
		CFG_BAND_FIRST = 2'd1,
		CFG_BAND_LAST  = 2'd2
	} cfg_reg_t;

	// control from the line walker to the output stage
	typedef struct packed {
		logic emit;
		logic last;
	} step_ctrl_t;

endpackage

`default_nettype wire

>>> sv/lsr_cfg_regs.sv
// ----------------------------------------------------------------------------
// lsr_cfg_regs: configuration register bank
// grid width and row band limits, written through the config channel
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_cfg_regs #(
	parameter int unsigned COORD_BITS = lsr_pkg::LSR_COORD_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [lsr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [COORD_BITS:0]                 cfg_data,
	output logic [COORD_BITS:0]                      grid_width,
	output logic [COORD_BITS-1:0]                    band_first,
	output logic [COORD_BITS-1:0]                    band_last
);
	import lsr_pkg::*;

	logic [COORD_BITS:0]   grid_width_q;
	logic [COORD_BITS-1:0] band_first_q;
	logic [COORD_BITS-1:0] band_last_q;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= (COORD_BITS+1)'(1) << COORD_BITS;
			band_first_q <= '0;
			band_last_q  <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_GRID_WIDTH: grid_width_q <= cfg_data;
				CFG_BAND_FIRST: band_first_q <= cfg_data[COORD_BITS-1:0];
				CFG_BAND_LAST:  band_last_q  <= cfg_data[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign grid_width = grid_width_q;
	assign band_first = band_first_q;
	assign band_last  = band_last_q;

endmodule

`default_nettype wire

>>> sv/lsr_walker.sv
// ----------------------------------------------------------------------------
// lsr_walker: bresenham line state and per-pixel step
// holds the current point, the end point and the error term of the line
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lsr_walker #(
	parameter int unsigned COORD_BITS = lsr_pkg::LSR_COORD_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load_fire,
	input  wire logic                  step_fire,
	input  wire logic [COORD_BITS-1:0] start_x,
	input  wire logic [COORD_BITS-1:0] start_y,
	input  wire logic [COORD_BITS-1:0] end_x,
	input  wire logic [COORD_BITS-1:0] end_y,
	output logic [COORD_BITS-1:0]      pix_x,
	output logic [COORD_BITS-1:0]      pix_y,
	output lsr_pkg::step_ctrl_t        ctrl
);
	import lsr_pkg::*;

	// line state
	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, stop_x_q, stop_y_q;
	logic [COORD_BITS:0]   err_q;
	logic [COORD_BITS:0]   twice_major_q, twice_minor_q;
	logic                  x_major_q, x_down_q, y_down_q;
	logic                  active_q;

	// load setup
	logic                  ld_x_down, ld_y_down, ld_x_major;
	logic [COORD_BITS-1:0] ld_adx, ld_ady, ld_major, ld_minor;

	// step datapath
	logic                  last;
	logic [COORD_BITS+1:0] err_sub;
	logic [COORD_BITS:0]   err_add;
	logic                  minor_step;
	logic [COORD_BITS-1:0] x_next_c, y_next_c;
	logic [COORD_BITS:0]   err_next;
	logic                  advance;

	// deltas and octant of a new line
	always_comb begin
		ld_x_down  = end_x < start_x;
		ld_y_down  = end_y < start_y;
		ld_adx     = ld_x_down ? start_x - end_x : end_x - start_x;
		ld_ady     = ld_y_down ? start_y - end_y : end_y - start_y;
		ld_x_major = ld_adx >= ld_ady;
		ld_major   = ld_x_major ? ld_adx : ld_ady;
		ld_minor   = ld_x_major ? ld_ady : ld_adx;
	end

	// error update and next point
	always_comb begin
		last = x_major_q ? (cur_x_q == stop_x_q) : (cur_y_q == stop_y_q);
		err_sub = {1'b0, err_q} - {1'b0, twice_minor_q};
		// restored term always lands in 0 .. twice the major delta
		err_add = err_sub[COORD_BITS:0] + twice_major_q;
		minor_step = err_sub[COORD_BITS+1] || (x_down_q && (err_sub == '0));
		err_next = minor_step ? err_add : err_sub[COORD_BITS:0];
		x_next_c = cur_x_q;
		y_next_c = cur_y_q;
		if (x_major_q || minor_step)
			x_next_c = x_down_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
		if (!x_major_q || minor_step)
			y_next_c = y_down_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
	end

	assign advance = step_fire && active_q;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			stop_x_q      <= '0;
			stop_y_q      <= '0;
			err_q         <= '0;
			twice_major_q <= '0;
			twice_minor_q <= '0;
			x_major_q     <= 1'b0;
			x_down_q      <= 1'b0;
			y_down_q      <= 1'b0;
			active_q      <= 1'b0;
		end else if (load_fire) begin
			cur_x_q       <= start_x;
			cur_y_q       <= start_y;
			stop_x_q      <= end_x;
			stop_y_q      <= end_y;
			err_q         <= {1'b0, ld_major};
			twice_major_q <= {ld_major, 1'b0};
			twice_minor_q <= {ld_minor, 1'b0};
			x_major_q     <= ld_x_major;
			x_down_q      <= ld_x_down;
			y_down_q      <= ld_y_down;
			active_q      <= (start_x != end_x) || (start_y != end_y);
		end else if (advance) begin
			if (last) begin
				active_q <= 1'b0;
			end else begin
				cur_x_q <= x_next_c;
				cur_y_q <= y_next_c;
				err_q   <= err_next;
			end
		end
	end

	// current pixel goes to the output stage
	assign pix_x     = cur_x_q;
	assign pix_y     = cur_y_q;
	assign ctrl.emit = advance;
	assign ctrl.last = last;

	// a non-final pixel always moves the point
	`ASSERT_CLK(a_step_moves, clk, arst_n,
		(advance && !last) |=> (cur_x_q != $past(cur_x_q)) || (cur_y_q != $past(cur_y_q)))
	// the error term never exceeds twice the major delta
	`ASSERT_NEVER(a_err_bound, clk, arst_n, err_q > twice_major_q)
	// minor delta never exceeds major delta
	`ASSERT_NEVER(a_delta_order, clk, arst_n, twice_minor_q > twice_major_q)
	// the final pixel ends the line
	`ASSERT_CLK(a_last_ends, clk, arst_n, (advance && last && !load_fire) |=> !active_q)

endmodule

`default_nettype wire

>>> sv/lsr_out_stage.sv
// ----------------------------------------------------------------------------
// lsr_out_stage: cell address, band test and result register
// forms one result per emitted pixel and holds it until it is taken
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lsr_out_stage #(
	parameter int unsigned COORD_BITS = lsr_pkg::LSR_COORD_BITS,
	localparam int unsigned ADDR_BITS = 2*COORD_BITS + 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [COORD_BITS:0]   grid_width,
	input  wire logic [COORD_BITS-1:0] band_first,
	input  wire logic [COORD_BITS-1:0] band_last,
	input  wire logic [COORD_BITS-1:0] pix_x,
	input  wire logic [COORD_BITS-1:0] pix_y,
	input  wire lsr_pkg::step_ctrl_t   ctrl,
	input  wire logic                  res_ready,
	output logic                       res_valid,
	output logic [COORD_BITS-1:0]      res_x,
	output logic [COORD_BITS-1:0]      res_y,
	output logic [ADDR_BITS-1:0]       res_addr,
	output logic                       res_in_band,
	output logic                       res_last
);
	import lsr_pkg::*;

	logic                      valid_q;
	logic [COORD_BITS-1:0]     x_q, y_q;
	logic [ADDR_BITS-1:0]      addr_q;
	logic                      in_band_q, last_q;
	logic [COORD_BITS:0]       row_ofs;
	logic [2*COORD_BITS+1:0]   addr_full;
	logic                      in_band_c;

	// (row + 2) * width + column, wrapped to the address width
	always_comb begin
		row_ofs   = {1'b0, pix_y} + (COORD_BITS+1)'(2);
		addr_full = (2*COORD_BITS+2)'(row_ofs) * (2*COORD_BITS+2)'(grid_width)
			+ (2*COORD_BITS+2)'(pix_x);
		in_band_c = (band_first <= pix_y) && (pix_y <= band_last);
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (ctrl.emit)
			valid_q <= 1'b1;
		else if (res_ready)
			valid_q <= 1'b0;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			x_q       <= pix_x;
			y_q       <= pix_y;
			addr_q    <= addr_full[ADDR_BITS-1:0];
			in_band_q <= in_band_c;
			last_q    <= ctrl.last;
		end
	end

	assign res_valid   = valid_q;
	assign res_x       = x_q;
	assign res_y       = y_q;
	assign res_addr    = addr_q;
	assign res_in_band = in_band_q;
	assign res_last    = last_q;

	// a new pixel only lands in a free or draining slot
	`ASSERT_CLK(a_no_overwrite, clk, arst_n, ctrl.emit |-> (!valid_q || res_ready))
	// an emitted pixel shows up as a result next cycle
	`ASSERT_CLK(a_emit_shows, clk, arst_n, ctrl.emit |=> valid_q)

endmodule

`default_nettype wire

>>> sv/line_segment_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// line_segment_rasterizer_unit: bresenham line rasterizer, all octants
//
// Items arrive on the s_ stream: s_tuser is the kind (load or step), s_tdata
// carries the two endpoints. A load transfer sets up a new line and gives no
// result; each step transfer gives the next pixel of the line on the m_
// stream, end points included, with m_tlast on the final pixel. Steps with
// no line loaded give nothing. A line with equal endpoints draws nothing.
// Results appear in the cycle after the step transfer (walker state, then one
// multiply-add for the cell address into the result register). One item is
// taken every cycle while m_tready is high; when the receiver stalls, the
// held result blocks s_tready until it is taken, and no pixel is lost.
// The cfg channel writes grid width and row band and is always ready; the
// user writes it while no item is in flight, the block does not enforce it.
// Reset clears the line (no line loaded) and sets grid width to 2^COORD_BITS
// and the band to all rows.
// ----------------------------------------------------------------------------
`default_nettype none

module line_segment_rasterizer_unit #(
	parameter int unsigned COORD_BITS = lsr_pkg::LSR_COORD_BITS,
	localparam int unsigned ADDR_BITS = 2*COORD_BITS + 1,
	localparam int unsigned IN_BITS   = ((4*COORD_BITS + 7) / 8) * 8,
	localparam int unsigned OUT_FLDS  = 2*COORD_BITS + ADDR_BITS,
	localparam int unsigned OUT_BITS  = ((OUT_FLDS + 7) / 8) * 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// input item stream
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// start_x, start_y, end_x, end_y from bit 0 up
	input  wire logic [IN_BITS-1:0]               s_tdata,
	// kind
	input  wire logic                             s_tuser,
	// result stream
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// pixel_x, pixel_y, cell_address from bit 0 up, zero padded
	output logic [OUT_BITS-1:0]                   m_tdata,
	// in_band
	output logic                                  m_tuser,
	// last_pixel
	output logic                                  m_tlast,
	// configuration write channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [lsr_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [COORD_BITS:0]              cfg_data
);
	import lsr_pkg::*;

	logic                  in_xfer, load_fire, step_fire;
	logic [COORD_BITS:0]   grid_width;
	logic [COORD_BITS-1:0] band_first, band_last;
	logic [COORD_BITS-1:0] pix_x, pix_y;
	step_ctrl_t            ctrl;
	logic [COORD_BITS-1:0] res_x, res_y;
	logic [ADDR_BITS-1:0]  res_addr;

	// input transfer decode
	assign s_tready  = !m_tvalid || m_tready;
	assign in_xfer   = s_tvalid && s_tready;
	assign load_fire = in_xfer && (item_kind_t'(s_tuser) == KIND_LOAD);
	assign step_fire = in_xfer && (item_kind_t'(s_tuser) == KIND_STEP);

	lsr_cfg_regs #(.COORD_BITS(COORD_BITS)) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.grid_width (grid_width),
		.band_first (band_first),
		.band_last  (band_last)
	);

	lsr_walker #(.COORD_BITS(COORD_BITS)) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_fire (load_fire),
		.step_fire (step_fire),
		.start_x   (s_tdata[COORD_BITS-1:0]),
		.start_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.end_x     (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
		.end_y     (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
		.pix_x     (pix_x),
		.pix_y     (pix_y),
		.ctrl      (ctrl)
	);

	lsr_out_stage #(.COORD_BITS(COORD_BITS)) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.grid_width  (grid_width),
		.band_first  (band_first),
		.band_last   (band_last),
		.pix_x       (pix_x),
		.pix_y       (pix_y),
		.ctrl        (ctrl),
		.res_ready   (m_tready),
		.res_valid   (m_tvalid),
		.res_x       (res_x),
		.res_y       (res_y),
		.res_addr    (res_addr),
		.res_in_band (m_tuser),
		.res_last    (m_tlast)
	);

	// pack the result fields
	assign m_tdata = {{(OUT_BITS-OUT_FLDS){1'b0}}, res_addr, res_y, res_x};

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for line_segment_rasterizer_unit
// drives load and step transfers with random gaps and receiver stalls,
// predicts every pixel with a bresenham walker of its own and compares
// each m_ transfer against the oldest predicted pixel
// ----------------------------------------------------------------------------

module tb;
	import lsr_pkg::*;

	localparam int unsigned COORD_MAX = (1 << LSR_COORD_BITS) - 1;
	localparam int unsigned ADDR_BITS = 2*LSR_COORD_BITS + 1;
	localparam int unsigned ROW_OFFSET = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PHASE_ITEMS = 170;
	localparam int unsigned REPORT_CAP = 40;

	typedef logic [LSR_COORD_BITS-1:0] coord_t;
	typedef logic [LSR_COORD_BITS:0] cfg_word_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic in_band;
		logic [ADDR_BITS-1:0] cell_address;
		logic last;
	} pixel_t;

	// walker model, register copy and queue of predicted pixels
	class raster_scoreboard;
		pixel_t expected_pixels[$];
		cfg_word_t grid_width;
		coord_t band_first, band_last;
		coord_t cur_x, cur_y, stop_x, stop_y;
		int error_term, twice_major, twice_minor;
		bit x_major, x_down, y_down, line_active;
		int mismatches, pixels_checked;

		function new();
			grid_width = cfg_word_t'(COORD_MAX + 1);
			band_first = '0;
			band_last = coord_t'(COORD_MAX);
			cur_x = '0;
			cur_y = '0;
			stop_x = '0;
			stop_y = '0;
			error_term = 0;
			twice_major = 0;
			twice_minor = 0;
			x_major = 0;
			x_down = 0;
			y_down = 0;
			line_active = 0;
			mismatches = 0;
			pixels_checked = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, cfg_word_t data);
			case (idx)
				CFG_GRID_WIDTH: grid_width = data;
				CFG_BAND_FIRST: band_first = data[LSR_COORD_BITS-1:0];
				CFG_BAND_LAST:  band_last = data[LSR_COORD_BITS-1:0];
				default: ;
			endcase
		endfunction

		// returns 1 when the transfer yields a pixel
		function bit note_item(item_kind_t kind, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
			int dx, dy, adx, ady;
			logic [31:0] addr;
			pixel_t px;
			bit last;
			if (kind == KIND_LOAD) begin
				dx = int'(ex) - int'(sx);
				dy = int'(ey) - int'(sy);
				adx = (dx < 0) ? -dx : dx;
				ady = (dy < 0) ? -dy : dy;
				x_major = adx >= ady;
				x_down = dx < 0;
				y_down = dy < 0;
				cur_x = sx;
				cur_y = sy;
				stop_x = ex;
				stop_y = ey;
				error_term = x_major ? adx : ady;
				twice_major = 2 * error_term;
				twice_minor = 2 * (x_major ? ady : adx);
				line_active = (dx != 0) || (dy != 0);
				return 1'b0;
			end
			if (!line_active)
				return 1'b0;

			// current pixel
			last = x_major ? (cur_x == stop_x) : (cur_y == stop_y);
			addr = (32'(cur_y) + ROW_OFFSET) * 32'(grid_width) + 32'(cur_x);
			px.x = cur_x;
			px.y = cur_y;
			px.in_band = (band_first <= cur_y) && (cur_y <= band_last);
			px.cell_address = addr[ADDR_BITS-1:0];
			px.last = last;
			expected_pixels.push_back(px);
			if (last) begin
				line_active = 0;
				return 1'b1;
			end

			// major axis always moves, minor axis when the error runs out
			if (x_major)
				cur_x = x_down ? cur_x - 1'b1 : cur_x + 1'b1;
			else
				cur_y = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
			error_term -= twice_minor;
			// ties take the minor step toward the end when x runs downward
			if (error_term < 0 || (x_down && error_term == 0)) begin
				if (x_major)
					cur_y = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
				else
					cur_x = x_down ? cur_x - 1'b1 : cur_x + 1'b1;
				error_term += twice_major;
			end
			return 1'b1;
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$display("%0t: unexpected pixel x=%0d y=%0d in_band=%0d addr=%0d last=%0d",
						$time, got.x, got.y, got.in_band, got.cell_address, got.last);
				return;
			end
			want = expected_pixels.pop_front();
			pixels_checked++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_CAP) begin
					$display("%0t: pixel mismatch, expected x=%0d y=%0d in_band=%0d addr=%0d last=%0d",
						$time, want.x, want.y, want.in_band, want.cell_address, want.last);
					$display("%0t:                   actual x=%0d y=%0d in_band=%0d addr=%0d last=%0d",
						$time, got.x, got.y, got.in_band, got.cell_address, got.last);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [4*LSR_COORD_BITS-1:0] s_tdata = '0;
	logic s_tuser = KIND_LOAD;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = CFG_GRID_WIDTH;
	cfg_word_t cfg_data = '0;

	raster_scoreboard sb;
	bit src_idle = 1'b1;
	bit sink_stalls = 1'b1;
	int items_done = 0;
	int load_count = 0;
	int step_count = 0;
	int idle_steps = 0;
	int setting_count = 0;

	line_segment_rasterizer_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("line_segment_rasterizer_unit test failed");
		$finish;
	end

	// gap length: mostly short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// coordinate biased toward both edges of the grid
	function automatic coord_t pick_coord();
		case ($urandom_range(0, 3))
			0: return coord_t'($urandom_range(0, 15));
			1: return coord_t'(COORD_MAX - $urandom_range(0, 15));
			default: return coord_t'($urandom_range(0, COORD_MAX));
		endcase
	endfunction

	// nearby coordinate, clamped to the grid
	function automatic coord_t nudge_coord(coord_t c, int span);
		int v;
		v = int'(c) + int'($urandom_range(0, 2*span)) - span;
		if (v < 0)
			v = 0;
		if (v > int'(COORD_MAX))
			v = COORD_MAX;
		return coord_t'(v);
	endfunction

	// receiver side ready with random stalls
	initial begin : sink_ctrl
		int hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				m_tready <= 1'b1;
				if (sink_stalls && $urandom_range(0, 3) == 0)
					hold = idle_len();
			end
		end
	end

	// result transfer check
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_pixel({m_tdata[LSR_COORD_BITS-1:0],
				m_tdata[2*LSR_COORD_BITS-1:LSR_COORD_BITS], m_tuser,
				m_tdata[2*LSR_COORD_BITS+ADDR_BITS-1:2*LSR_COORD_BITS], m_tlast});
	end

	// one input transfer, with an optional gap ahead of it
	task automatic send_item(item_kind_t kind, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
		int gap;
		gap = (src_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {ey, ex, sy, sx};
		do @(posedge clk); while (!s_tready);
		if (kind == KIND_LOAD) begin
			load_count++;
			items_done++;
		end else begin
			step_count++;
			if (sb.note_item(kind, sx, sy, ex, ey))
				items_done++;
			else
				idle_steps++;
		end
		if (kind == KIND_LOAD)
			void'(sb.note_item(kind, sx, sy, ex, ey));
	endtask

	// load a line and step it a given number of times
	task automatic draw_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey, int steps);
		int i;
		send_item(KIND_LOAD, sx, sy, ex, ey);
		for (i = 0; i < steps; i++)
			send_item(KIND_STEP, coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), coord_t'($urandom));
	endtask

	// stop sending and wait for every predicted pixel
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write transfer
	task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, cfg_word_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// full register setting; band writes carry a random spare top bit
	task automatic apply_setting(cfg_word_t gw, coord_t bf, coord_t bl);
		cfg_write(CFG_GRID_WIDTH, gw);
		cfg_write(CFG_BAND_FIRST, {1'($urandom_range(0, 1)), bf});
		cfg_write(CFG_BAND_LAST, {1'($urandom_range(0, 1)), bl});
		if ($urandom_range(0, 1) == 0)
			cfg_write(CFG_SPARE, cfg_word_t'($urandom));
		setting_count++;
	endtask

	// main sequence
	initial begin : main_seq
		int phase, mode, span, steps, pixels, adx, ady, phase_target;
		coord_t sx, sy, ex, ey;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: step with no line, zero length, ties both ways, edges,
		// steep lines, vertical upward, abandoned line, horizontal leftward
		send_item(KIND_STEP, coord_t'(COORD_MAX), coord_t'(COORD_MAX),
			coord_t'(COORD_MAX), coord_t'(COORD_MAX));
		draw_line(5, 5, 5, 5, 1);
		draw_line(0, 0, 2, 1, 3);
		draw_line(coord_t'(COORD_MAX), coord_t'(COORD_MAX),
			coord_t'(COORD_MAX - 2), coord_t'(COORD_MAX - 1), 4);
		draw_line(0, coord_t'(COORD_MAX), 1, coord_t'(COORD_MAX - 2), 3);
		draw_line(coord_t'(COORD_MAX), 1, coord_t'(COORD_MAX), 0, 2);
		draw_line(10, 10, 20, 12, 1);
		draw_line(2, 7, 0, 7, 3);

		// random phases, each with its own register setting
		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: apply_setting(0, 0, coord_t'(COORD_MAX));
				1: apply_setting(cfg_word_t'((1 << (LSR_COORD_BITS + 1)) - 1),
					coord_t'(COORD_MAX), coord_t'(COORD_MAX));
				2: apply_setting(1, 0, 0);
				3: apply_setting(cfg_word_t'(COORD_MAX + 1), 2000, 1000);
				default: apply_setting(cfg_word_t'($urandom),
					coord_t'($urandom), coord_t'($urandom));
			endcase
			mode = $urandom_range(0, 3);
			src_idle = (mode == 0) || (mode == 1);
			sink_stalls = (mode == 0) || (mode == 2);
			phase_target = items_done + PHASE_ITEMS;
			while (items_done < phase_target) begin
				case ($urandom_range(0, 49))
					0, 1: send_item(KIND_STEP, coord_t'($urandom), coord_t'($urandom),
						coord_t'($urandom), coord_t'($urandom));
					2: begin
						sx = pick_coord();
						sy = pick_coord();
						draw_line(sx, sy, sx, sy, $urandom_range(0, 2));
					end
					3, 4: draw_line(coord_t'($urandom), coord_t'($urandom),
						coord_t'($urandom), coord_t'($urandom), $urandom_range(0, 3));
					5: settle();
					default: begin
						span = ($urandom_range(0, 39) == 0) ? 200 : 12;
						sx = pick_coord();
						sy = pick_coord();
						ex = nudge_coord(sx, span);
						ey = nudge_coord(sy, span);
						case ($urandom_range(0, 9))
							0: ey = sy;
							1: ex = sx;
							default: ;
						endcase
						adx = (ex > sx) ? int'(ex - sx) : int'(sx - ex);
						ady = (ey > sy) ? int'(ey - sy) : int'(sy - ey);
						pixels = ((adx > ady) ? adx : ady) + 1;
						if ($urandom_range(0, 7) == 0)
							steps = $urandom_range(0, pixels - 1);
						else
							steps = pixels + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
						draw_line(sx, sy, ex, ey, steps);
					end
				endcase
			end
		end

		settle();
		$display("covered %0d loads and %0d steps (%0d with no line active), %0d pixels checked",
			load_count, step_count, idle_steps, sb.pixels_checked);
		$display("across %0d register settings incl. zero width, address wrap and an empty band",
			setting_count);
		if (sb.mismatches == 0 && sb.expected_pixels.size() == 0)
			$display("line_segment_rasterizer_unit test passed");
		else
			$display("line_segment_rasterizer_unit test failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/lsr_pkg.sv
sv/lsr_cfg_regs.sv
sv/lsr_walker.sv
sv/lsr_out_stage.sv
sv/line_segment_rasterizer_unit.sv
tb/tb.sv
